### src/pcod_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcod_pkg: shared types and constants
// Widths, sequencer states and the dither rank function of the ordered dither.
// ----------------------------------------------------------------------------
package pcod_pkg;

  localparam int CandidateCount = 64;
  localparam int PaletteSize    = 16;
  localparam int CompBits       = 16;
  localparam int IdxBits        = 4;
  localparam int CandBits       = $clog2(CandidateCount);
  localparam int CandCntBits    = $clog2(CandidateCount + 1);
  localparam int PalBits        = $clog2(PaletteSize);
  localparam int DistBits       = 2 * CompBits + 2;

  localparam logic [CompBits-1:0] CompMax = {CompBits{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_COUNT,
    ST_SCAN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [CompBits-1:0] red;
    logic [CompBits-1:0] green;
    logic [CompBits-1:0] blue;
  } colour_t;

  function automatic logic [CandBits-1:0] bayer_rank(input logic [2:0] row,
                                                     input logic [2:0] col);
    logic [2:0] m;
    logic [5:0] a;
    logic [5:0] b;
    logic [6:0] s;
    logic [12:0] p;
    begin
      m = row ^ col;
      a = {1'b0, col[0], 1'b0, col[1], 1'b0, col[2]};
      b = {m[0], 1'b0, m[1], 1'b0, m[2], 1'b0};
      s = {1'b0, a} + {1'b0, b};
      p = 13'(s) * 13'(CandidateCount);
      bayer_rank = CandBits'(p >> 6);
    end
  endfunction

endpackage

### src/pcod_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcod_in_if / pcod_out_if: valid/ready channels
// Input items and result items of the ordered dither.
// ----------------------------------------------------------------------------
interface pcod_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  entry_index;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;
  logic [15:0] entry_luma;
  logic [2:0]  pixel_x_low;
  logic [2:0]  pixel_y_low;
  modport source (output valid, kind, entry_index, red, green, blue, entry_luma,
                  pixel_x_low, pixel_y_low, input ready);
  modport sink (input valid, kind, entry_index, red, green, blue, entry_luma,
                pixel_x_low, pixel_y_low, output ready);
endinterface

interface pcod_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] colour_index;
  modport source (output valid, colour_index, input ready);
  modport sink (input valid, colour_index, output ready);
endinterface

### src/pcod_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcod_search: shared nearest-entry unit
// Compares one palette entry per cycle against the trial colour.
// ----------------------------------------------------------------------------
module pcod_search (
  input  logic                                clk,
  input  logic                                start,
  input  logic                                step,
  input  pcod_pkg::colour_t                   trial,
  input  pcod_pkg::colour_t                   entry,
  input  logic [pcod_pkg::PalBits-1:0]        entry_idx,
  output logic [pcod_pkg::PalBits-1:0]        best_idx
);
  import pcod_pkg::*;

  logic [DistBits-1:0] best_d_r;
  logic [PalBits-1:0]  best_idx_r;
  logic [DistBits-1:0] dist_sum;

  function automatic logic [2*CompBits-1:0] sq(input logic [CompBits-1:0] a,
                                               input logic [CompBits-1:0] b);
    logic [CompBits-1:0] d;
    begin
      d = (a > b) ? a - b : b - a;
      sq = (2*CompBits)'(d) * (2*CompBits)'(d);
    end
  endfunction

  assign dist_sum = DistBits'(sq(trial.red, entry.red))
                  + DistBits'(sq(trial.green, entry.green))
                  + DistBits'(sq(trial.blue, entry.blue));

  always_ff @(posedge clk) begin
    if (step && (start || dist_sum < best_d_r)) begin
      best_d_r   <= dist_sum;
      best_idx_r <= entry_idx;
    end
  end

  assign best_idx = best_idx_r;
endmodule

### src/palette_candidate_ordered_dither.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_candidate_ordered_dither: 8x8 candidate ordered dither
// Loads a palette, then maps each pixel to a palette index.
// ----------------------------------------------------------------------------
// Input channel in_*: a load item (kind 0) writes one palette entry and
// gives no result. A pixel item (kind 1) gives one colour_index on
// out_*. Entries must be loaded before any pixel uses them.
// Each pixel runs 64 candidate steps; one step scans the 16 entries through
// one shared distance unit and then updates the trial colour. Rank selection
// probes entries in order; each probe sums, one entry per cycle, the
// candidates of lower and equal luma (1 to 16 probes), then a scan of the
// candidate list in creation order picks the candidate at the rank.
// in_ready is low while a pixel is at work and while a result waits.
// A stalled out_ready holds the result and the block. Reset (rst_n low,
// synchronous) returns the sequencer to idle; the palette is not cleared.
// ----------------------------------------------------------------------------
module palette_candidate_ordered_dither (
  input  logic clk,
  input  logic rst_n,
  pcod_in_if.sink    in_ch,
  pcod_out_if.source out_ch
);
  import pcod_pkg::*;

  colour_t             pal_col [PaletteSize];
  logic [CompBits-1:0] pal_luma [PaletteSize];
  logic [PalBits-1:0]  cand_mem [CandidateCount];

  state_t               state_r, state_nxt;
  colour_t              pix_r, trial_r;
  logic [2:0]           px_r, py_r;
  logic [PalBits-1:0]   ent_r;
  logic [PalBits-1:0]   sub_r;
  logic [CandCntBits-1:0] cand_r;
  logic [CandCntBits-1:0] hist_r [PaletteSize];
  logic [CandCntBits-1:0] lt_r, eq_r;
  logic [CandCntBits-1:0] below_r;
  logic [CandCntBits-1:0] scan_r;
  logic [CandCntBits-1:0] tie_r;
  logic [CandBits-1:0]  rank_r;
  logic [CompBits-1:0]  tgt_luma_r;
  logic [PalBits-1:0]   rd_r;
  logic                 rd_vld_r;
  logic [IdxBits-1:0]   res_r;
  logic [PalBits-1:0]   best_idx;
  logic                 step;
  colour_t              sel;
  colour_t              upd;
  logic [CandCntBits-1:0] lt_sum, eq_sum;
  logic                 probe_last;
  logic                 find_hit;
  logic                 scan_hit;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_RESULT);
  assign out_ch.colour_index = res_r;

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready && !in_ch.kind &&
        {1'b0, in_ch.entry_index} < (IdxBits+1)'(PaletteSize)) begin
      pal_col[PalBits'(in_ch.entry_index)]  <= '{in_ch.red, in_ch.green, in_ch.blue};
      pal_luma[PalBits'(in_ch.entry_index)] <= in_ch.entry_luma;
    end
  end

  assign step = (state_r == ST_SEARCH);

  pcod_search u_search (
    .clk(clk), .start(ent_r == '0), .step(step), .trial(trial_r),
    .entry(pal_col[ent_r]), .entry_idx(ent_r), .best_idx(best_idx)
  );

  function automatic logic [CompBits-1:0] upd_c(input logic [CompBits-1:0] t,
                                                input logic [CompBits-1:0] p,
                                                input logic [CompBits-1:0] e);
    logic signed [CompBits+2:0] v;
    begin
      v = $signed({3'b0, t}) + $signed({3'b0, p}) - $signed({3'b0, e});
      if (v < 0) upd_c = '0;
      else if (v > $signed({3'b0, CompMax})) upd_c = CompMax;
      else upd_c = v[CompBits-1:0];
    end
  endfunction

  assign sel = pal_col[best_idx];
  assign upd = '{upd_c(trial_r.red, pix_r.red, sel.red),
                 upd_c(trial_r.green, pix_r.green, sel.green),
                 upd_c(trial_r.blue, pix_r.blue, sel.blue)};

  // rank selection: the probe entry's luma group holds sorted positions
  // [lower, lower + equal); within it candidates keep creation order.
  assign lt_sum = lt_r + ((pal_luma[sub_r] < pal_luma[ent_r]) ? hist_r[sub_r] : '0);
  assign eq_sum = eq_r + ((pal_luma[sub_r] == pal_luma[ent_r]) ? hist_r[sub_r] : '0);
  assign probe_last = (sub_r == PalBits'(PaletteSize - 1));
  assign find_hit = probe_last && (hist_r[ent_r] != '0) &&
                    ({1'b0, rank_r} >= lt_sum) && ({1'b0, rank_r} < lt_sum + eq_sum);
  assign scan_hit = rd_vld_r && (pal_luma[rd_r] == tgt_luma_r) &&
                    (below_r + tie_r == {1'b0, rank_r});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid && in_ch.kind) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (ent_r == PalBits'(PaletteSize - 1)) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (cand_r == CandCntBits'(CandidateCount - 1)) state_nxt = ST_COUNT;
        else state_nxt = ST_SEARCH;
      end
      ST_COUNT: begin
        if (find_hit) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_hit) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    rd_r <= cand_mem[scan_r[CandBits-1:0]];
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid && in_ch.kind) begin
          pix_r   <= '{in_ch.red, in_ch.green, in_ch.blue};
          trial_r <= '{in_ch.red, in_ch.green, in_ch.blue};
          px_r    <= in_ch.pixel_x_low;
          py_r    <= in_ch.pixel_y_low;
          ent_r   <= '0;
          cand_r  <= '0;
          for (int i = 0; i < PaletteSize; i++) hist_r[i] <= '0;
        end
      end
      ST_SEARCH: ent_r <= ent_r + 1'b1;
      ST_UPDATE: begin
        trial_r <= upd;
        cand_mem[cand_r[CandBits-1:0]] <= best_idx;
        hist_r[best_idx] <= hist_r[best_idx] + 1'b1;
        cand_r <= cand_r + 1'b1;
        ent_r  <= '0;
        sub_r  <= '0;
        lt_r   <= '0;
        eq_r   <= '0;
        rank_r <= bayer_rank(px_r, py_r);
      end
      ST_COUNT: begin
        sub_r <= sub_r + 1'b1;
        if (probe_last) begin
          lt_r <= '0;
          eq_r <= '0;
          if (find_hit) begin
            below_r    <= lt_sum;
            tgt_luma_r <= pal_luma[ent_r];
            scan_r     <= '0;
            tie_r      <= '0;
            rd_vld_r   <= 1'b0;
          end else begin
            ent_r <= ent_r + 1'b1;
          end
        end else begin
          lt_r <= lt_sum;
          eq_r <= eq_sum;
        end
      end
      ST_SCAN: begin
        rd_vld_r <= 1'b1;
        scan_r   <= scan_r + 1'b1;
        if (rd_vld_r && pal_luma[rd_r] == tgt_luma_r) begin
          if (below_r + tie_r == {1'b0, rank_r}) res_r <= IdxBits'(rd_r);
          tie_r <= tie_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.colour_index))
    else $error("result changed under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_r <= CandCntBits'(CandidateCount)))
    else $error("candidate scan overran");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("accepting while a result waits");
endmodule
